FILE: hw/rtl/mcl_pkg.sv
package mcl_pkg;

    // Default ring depth
    localparam int WINDOW_DEPTH_DEF = 10;

    // Field widths
    localparam int ACC_W     = 16;
    localparam int TIME_W    = 32;
    localparam int REG_W     = 16;
    localparam int MAG_W     = 17;
    localparam int ROOT_W    = 16;
    localparam int SQ_W      = 2 * ROOT_W;
    localparam int ENERGY_W  = 48;
    localparam int LVL_W     = 2;
    localparam int CFG_IDX_W = 3;

    // Square root runs one result bit per step
    localparam int ROOT_STEPS = ROOT_W;
    localparam int CNT_W      = $clog2(ROOT_STEPS);
    localparam int REM_W      = ROOT_W + 2;

    localparam logic [CNT_W-1:0] CNT_SQ_LAST   = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    // Square selector codes
    localparam logic [1:0] SQ_SEL_X = 2'd0;
    localparam logic [1:0] SQ_SEL_Y = 2'd1;

    localparam logic [MAG_W-1:0]    ONE_G_MAG  = MAG_W'(2509);
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STATIC_THR  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WALKING_THR = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_WALKING_RATE = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_RUNNING_RATE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = CFG_IDX_W'(4);

    // Configuration reset values
    localparam logic [REG_W-1:0] STATIC_THR_RST   = REG_W'(125);
    localparam logic [REG_W-1:0] WALKING_THR_RST  = REG_W'(376);
    localparam logic [REG_W-1:0] WALKING_RATE_RST = REG_W'(2450);
    localparam logic [REG_W-1:0] RUNNING_RATE_RST = REG_W'(4900);
    localparam logic [REG_W-1:0] MIN_INTERVAL_RST = REG_W'(1000);

    // Motion levels
    localparam logic [LVL_W-1:0] LVL_STATIC  = LVL_W'(0);
    localparam logic [LVL_W-1:0] LVL_WALKING = LVL_W'(1);
    localparam logic [LVL_W-1:0] LVL_RUNNING = LVL_W'(2);

    // Item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic                     op;
        logic signed [ACC_W-1:0]  accel_x;
        logic signed [ACC_W-1:0]  accel_y;
        logic signed [ACC_W-1:0]  accel_z;
        logic [TIME_W-1:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [LVL_W-1:0]    motion_state;
        logic                state_changed;
        logic [ENERGY_W-1:0] total_energy;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_SQUARE,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_RING_RD,
        ST_RING_UPD,
        ST_LIMITS,
        ST_CLASSIFY,
        ST_ENERGY_MUL,
        ST_ENERGY_ADD,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       load;
        logic       clear;
        logic       sq_first;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       ring_rd;
        logic       ring_upd;
        logic       limits;
        logic       classify;
        logic       energy_mul;
        logic       energy_add;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/mcl_in_if.sv
interface mcl_in_if import mcl_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/mcl_out_if.sv
interface mcl_out_if import mcl_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

FILE: hw/rtl/mcl_ram.sv
module mcl_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 10,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/mcl_ctrl.sv
module mcl_ctrl import mcl_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = (i_in_op == OP_CLEAR) ? ST_CLEAR : ST_SQUARE;
                end
            end
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_SQUARE: begin
                o_cmd.sq_sel   = r_cnt[1:0];
                o_cmd.sq_first = (r_cnt == '0);
                if (r_cnt == CNT_SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_ROOT_INIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ROOT_INIT: begin
                o_cmd.root_init = 1'b1;
                n_cnt           = '0;
                n_state         = ST_ROOT;
            end
            ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (r_cnt == CNT_ROOT_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_RING_RD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_RING_RD: begin
                o_cmd.ring_rd = 1'b1;
                n_state       = ST_RING_UPD;
            end
            ST_RING_UPD: begin
                o_cmd.ring_upd = 1'b1;
                n_state        = ST_LIMITS;
            end
            ST_LIMITS: begin
                o_cmd.limits = 1'b1;
                n_state      = ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
                o_cmd.classify = 1'b1;
                n_state        = ST_ENERGY_MUL;
            end
            ST_ENERGY_MUL: begin
                o_cmd.energy_mul = 1'b1;
                n_state          = ST_ENERGY_ADD;
            end
            ST_ENERGY_ADD: begin
                o_cmd.energy_add = 1'b1;
                n_state          = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register can take the item
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end
endmodule

FILE: hw/rtl/mcl_dp.sv
module mcl_dp import mcl_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    input  t_in_item             i_in_item,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_out_item            o_out_item
);
    localparam int AW    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW    = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = MAG_W + CW;
    localparam int LIM_W = REG_W + CW;

    // configuration
    logic [REG_W-1:0] r_static_thr, r_walking_thr, r_walking_rate, r_running_rate;
    logic [REG_W-1:0] r_min_interval;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_static_thr   <= STATIC_THR_RST;
            r_walking_thr  <= WALKING_THR_RST;
            r_walking_rate <= WALKING_RATE_RST;
            r_running_rate <= RUNNING_RATE_RST;
            r_min_interval <= MIN_INTERVAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STATIC_THR:   r_static_thr   <= i_cfg_data;
                CFG_WALKING_THR:  r_walking_thr  <= i_cfg_data;
                CFG_WALKING_RATE: r_walking_rate <= i_cfg_data;
                CFG_RUNNING_RATE: r_running_rate <= i_cfg_data;
                CFG_MIN_INTERVAL: r_min_interval <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // captured item
    t_in_item r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    // sum of squares over a shared squarer
    logic signed [ACC_W-1:0] sq_in;
    logic signed [SQ_W-1:0]  sq_full;
    logic [SQ_W-1:0]         r_prod, r_acc;

    always_comb begin
        case (i_cmd.sq_sel)
            SQ_SEL_X: sq_in = r_item.accel_x;
            SQ_SEL_Y: sq_in = r_item.accel_y;
            default:  sq_in = r_item.accel_z;
        endcase
        sq_full = sq_in * sq_in;
    end

    always_ff @(posedge i_clk) begin
        r_prod <= unsigned'(sq_full);
        if (i_cmd.sq_first) begin
            r_acc <= '0;
        end else begin
            r_acc <= r_acc + r_prod;
        end
    end

    // square root, one result bit per step
    logic [SQ_W-1:0]    r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [REM_W+1:0]   rem_sh, trial, rem_sub;

    always_comb begin
        rem_sh  = {r_rem, r_rad[SQ_W-1 -: 2]};
        trial   = {2'b00, r_root, 2'b01};
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.root_init) begin
            r_rad  <= r_acc;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.root_step) begin
            r_rad <= {r_rad[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= rem_sub[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    // change ring
    logic [MAG_W-1:0] mag, r_last_mag, r_diff, ram_rdata, old_diff;
    logic [AW-1:0]    r_ptr;
    logic             r_full;
    logic [SUM_W-1:0] r_sum;
    logic [CW-1:0]    count;

    assign mag      = MAG_W'(r_root);
    assign old_diff = r_full ? ram_rdata : '0;
    assign count    = r_full ? CW'(WINDOW_DEPTH) : CW'(r_ptr);

    mcl_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ring_upd),
        .i_waddr (r_ptr),
        .i_wdata (r_diff),
        .i_re    (i_cmd.ring_rd),
        .i_raddr (r_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_mag <= ONE_G_MAG;
            r_ptr      <= '0;
            r_full     <= 1'b0;
            r_sum      <= '0;
        end else begin
            if (i_cmd.ring_rd) begin
                r_last_mag <= mag;
            end
            if (i_cmd.ring_upd) begin
                r_sum <= r_sum - SUM_W'(old_diff) + SUM_W'(r_diff);
                if (r_ptr == AW'(WINDOW_DEPTH - 1)) begin
                    r_ptr  <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_rd) begin
            r_diff <= (mag >= r_last_mag) ? (mag - r_last_mag) : (r_last_mag - mag);
        end
    end

    // classification
    logic [LIM_W-1:0]  r_lim_s, r_lim_w;
    logic [LVL_W-1:0]  r_level, level;
    logic              r_changed;
    logic [TIME_W-1:0] r_elapsed, r_mark;

    always_ff @(posedge i_clk) begin
        if (i_cmd.limits) begin
            r_lim_s <= LIM_W'(r_static_thr) * LIM_W'(count);
            r_lim_w <= LIM_W'(r_walking_thr) * LIM_W'(count);
        end
        if (i_cmd.classify) begin
            r_elapsed <= r_item.now_ms - r_mark;
        end
    end

    always_comb begin
        if (r_sum < SUM_W'(r_lim_s)) begin
            level = LVL_STATIC;
        end else if (r_sum < SUM_W'(r_lim_w)) begin
            level = LVL_WALKING;
        end else begin
            level = LVL_RUNNING;
        end
    end

    // energy
    logic [ENERGY_W-1:0] r_eprod, r_energy;
    logic [REG_W-1:0]    rate;
    logic [ENERGY_W:0]   energy_sum;

    assign rate       = (r_level == LVL_WALKING) ? r_walking_rate : r_running_rate;
    assign energy_sum = {1'b0, r_energy} + {1'b0, r_eprod};

    always_ff @(posedge i_clk) begin
        if (i_cmd.energy_mul) begin
            r_eprod <= ENERGY_W'(rate) * ENERGY_W'(r_elapsed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= LVL_STATIC;
            r_changed <= 1'b0;
            r_energy  <= '0;
            r_mark    <= '0;
        end else if (i_cmd.clear) begin
            r_changed <= 1'b0;
            r_energy  <= '0;
            r_mark    <= '0;
        end else begin
            if (i_cmd.classify) begin
                r_level   <= level;
                r_changed <= (level != r_level);
            end
            if (i_cmd.energy_add) begin
                if (r_mark == '0) begin
                    r_mark <= r_item.now_ms;
                end else if (r_elapsed >= TIME_W'(r_min_interval)) begin
                    if (r_level != LVL_STATIC) begin
                        r_energy <= energy_sum[ENERGY_W] ? ENERGY_MAX
                                                         : energy_sum[ENERGY_W-1:0];
                    end
                    r_mark <= r_item.now_ms;
                end
            end
        end
    end

    // output register
    logic      r_out_valid;
    t_out_item r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.motion_state  <= r_level;
            r_out.state_changed <= r_changed;
            r_out.total_energy  <= r_energy;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;
endmodule

FILE: hw/rtl/motion_level_classifier_core.sv
// Motion level classifier. Each sample item (op = 0) takes the magnitude of a
// three-axis acceleration as the floor of the integer square root of the sum
// of squares, pushes its absolute change into a ring of the last WINDOW_DEPTH
// changes, and classifies the motion as static, walking or running from the
// ring sum against the thresholds scaled by the fill count. While moving,
// energy grows by rate times elapsed milliseconds, at most once per
// min_interval_ms, saturating at 2^48-1. A clear item (op = 1) zeroes the
// energy and the time mark. Every item gives one result item. Most of the
// work for a sample is the 16-step square root unit (one result bit per
// cycle), which follows a pass over one shared squarer; a clear item skips
// both. The output register lets a finished result wait while the next
// item is taken in. The ring sits in a small RAM and needs no clearing
// pass after reset: entries past the fill point read as zero. Write
// configuration only while idle.
module motion_level_classifier_core import mcl_pkg::*; #(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data,
    mcl_in_if.sink               i_sample,
    mcl_out_if.source            o_result
);
    t_cmd    cmd;
    t_status status;

    // sequence the steps of one item
    mcl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_sample.valid),
        .i_in_op    (i_sample.item.op),
        .i_status   (status),
        .o_in_ready (i_sample.ready),
        .o_cmd      (cmd)
    );

    // squarer, root unit, ring, classifier, energy and output register
    mcl_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_item   (i_sample.item),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out_item  (o_result.item)
    );
endmodule
